// ===== rtl/core/dictzip_header_parser_top_assert.svh =====
// Assertion macros shared by the checker files of the dictzip header parser.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef DICTZIP_HEADER_PARSER_TOP_ASSERT_SVH
`define DICTZIP_HEADER_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DZHP_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dictzip header parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define DZHP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dictzip header parser check failed");

`endif

// ===== rtl/core/dzhp_pkg.sv =====
// Types and constants of the dictzip header parser.
// Used by the front, queue, back, top level and checker; depends on nothing.
package dzhp_pkg;

	localparam int OUT_TDATA_W = 184;

	localparam logic [7:0] GZIP_ID1 = 8'h1F;
	localparam logic [7:0] GZIP_ID2 = 8'h8B;
	localparam logic [7:0] SUB_ID1  = 8'h52;
	localparam logic [7:0] SUB_ID2  = 8'h41;

	localparam int FLG_FHCRC    = 1;
	localparam int FLG_FEXTRA   = 2;
	localparam int FLG_FNAME    = 3;
	localparam int FLG_FCOMMENT = 4;

	localparam logic [1:0] FT_TEXT    = 2'd0;
	localparam logic [1:0] FT_GZIP    = 2'd1;
	localparam logic [1:0] FT_DICTZIP = 2'd2;

	typedef enum logic [2:0] {
		EV_CHUNK        = 3'd0,
		EV_DONE         = 3'd1,
		EV_BAD_VERSION  = 3'd2,
		EV_ZERO_CHUNKS  = 3'd3,
		EV_LEN_MISMATCH = 3'd4
	} dzhp_event_t;

	typedef enum logic [18:0] {
		PH_WAIT    = 19'h00001,
		PH_MAGIC2  = 19'h00002,
		PH_METHOD  = 19'h00004,
		PH_FLAGS   = 19'h00008,
		PH_MTIME   = 19'h00010,
		PH_XFL     = 19'h00020,
		PH_OS      = 19'h00040,
		PH_XLEN    = 19'h00080,
		PH_SI1     = 19'h00100,
		PH_SI2     = 19'h00200,
		PH_SUBLEN  = 19'h00400,
		PH_VERSION = 19'h00800,
		PH_CLEN    = 19'h01000,
		PH_CCNT    = 19'h02000,
		PH_TABLE   = 19'h04000,
		PH_SKIP    = 19'h08000,
		PH_NAME    = 19'h10000,
		PH_COMMENT = 19'h20000,
		PH_HCRC    = 19'h40000
	} dzhp_phase_t;

	typedef struct packed {
		logic        has_chunk;
		logic        has_final;
		dzhp_event_t final_ev;
		logic [1:0]  chunk_type;
		logic [1:0]  file_type;
		logic [7:0]  flag_bits;
		logic [31:0] mod_time;
		logic [7:0]  os_code;
		logic [15:0] chunk_length;
		logic [15:0] chunk_count;
		logic [31:0] data_start;
		logic [15:0] chunk_index;
		logic [15:0] chunk_size;
		logic [31:0] chunk_offset;
	} dzhp_entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} dzhp_qstat_t;

endpackage

// ===== rtl/core/dictzip_header_parser_top.sv =====
// Top level of the dictzip header parser: parser front, result queue and output back end.
// Depends on dzhp_pkg, dzhp_front, dzhp_queue and dzhp_back.
//
// The slave stream takes one file byte per beat in tdata; tuser marks the byte at offset
// zero of a new file, which restarts parsing. The master stream gives one result per beat:
// tuser holds the event code, tlast marks the last result caused by one input byte, and
// tdata holds the header fields and, on chunk entries, the chunk table element.
// A byte is taken in every cycle while the result queue has room; a result passes from
// the queue through the output register to the master side. A byte that completes
// the chunk table and also ends the header gives two beats, which the back end sends one
// after the other, so the output port sets the sustained rate when such bytes follow closely.
// When the receiver stalls, results wait in the output register and the queue of
// QUEUE_DEPTH entries; once the queue is full, tready on the slave side drops.
// After reset the block is idle, waits for a byte marked as first, and ignores the rest.
module dictzip_header_parser_top
	import dzhp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]             s_axis_tuser,  // [0] first_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] file_type, [9:2] flag_bits, [41:10] mod_time, [49:42] os_code,
	// [65:50] chunk_length, [81:66] chunk_count, [113:82] data_start,
	// [129:114] chunk_index, [145:130] chunk_size, [177:146] chunk_offset, zero above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [2:0]             m_axis_tuser,  // [2:0] event_res
	output logic                   m_axis_tlast   // last_of_run
);

	dzhp_qstat_t qstat;
	dzhp_entry_t push_entry;
	dzhp_entry_t head;
	logic        push;
	logic        pop;

	dzhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.first_byte (s_axis_tuser[0]),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	dzhp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	dzhp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast)
	);

endmodule

// ===== rtl/core/dzhp_front.sv =====
// Front end of the dictzip header parser: accepts file bytes and runs the header state machine.
// Each byte that causes results pushes one entry into the queue. Depends on dzhp_pkg.
module dzhp_front
	import dzhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  dzhp_qstat_t qstat,
	output logic        push,
	output dzhp_entry_t push_entry
);

	dzhp_phase_t phase_q, n_phase;
	logic [31:0] bp_q, n_bp, bp_inc;
	logic [1:0]  step_q, n_step;
	logic [7:0]  low_q, n_low;
	logic [7:0]  flags_q, n_flags;
	logic [31:0] mtime_q, n_mtime;
	logic [7:0]  os_q, n_os;
	logic [16:0] xend_q, n_xend, xend_calc;
	logic [7:0]  sub_q, n_sub;
	logic [15:0] clen_q, n_clen;
	logic [15:0] ccnt_q, n_ccnt;
	logic [15:0] cnt_q, n_cnt, cnt_inc;
	logic [31:0] roff_q, n_roff;
	logic [1:0]  type_q, n_type;
	logic        lenbad_q, n_lenbad;
	logic [15:0] word;
	logic        accept;
	logic        tail_req;
	logic [1:0]  tail_from;
	logic        has_chunk, has_final;
	dzhp_event_t fin_ev;
	logic [31:0] fin_start;

	assign in_ready  = !qstat.full;
	assign accept    = in_valid && in_ready;
	assign word      = {data_byte, low_q};
	assign bp_inc    = (bp_q == 32'hFFFF_FFFF) ? bp_q : bp_q + 32'd1;
	assign xend_calc = 17'd12 + {1'b0, word};
	assign cnt_inc   = cnt_q + 16'd1;

	always_comb begin
		n_phase   = phase_q;
		n_bp      = bp_q;
		n_step    = step_q;
		n_low     = low_q;
		n_flags   = flags_q;
		n_mtime   = mtime_q;
		n_os      = os_q;
		n_xend    = xend_q;
		n_sub     = sub_q;
		n_clen    = clen_q;
		n_ccnt    = ccnt_q;
		n_cnt     = cnt_q;
		n_roff    = roff_q;
		n_type    = type_q;
		n_lenbad  = lenbad_q;
		tail_req  = 1'b0;
		tail_from = 2'd0;
		has_chunk = 1'b0;
		has_final = 1'b0;
		fin_ev    = EV_DONE;
		fin_start = 32'd0;
		if (accept && first_byte) begin
			n_phase  = PH_MAGIC2;
			n_bp     = 32'd1;
			n_step   = 2'd0;
			n_low    = data_byte;
			n_flags  = 8'd0;
			n_mtime  = 32'd0;
			n_os     = 8'd0;
			n_xend   = 17'd0;
			n_sub    = 8'd0;
			n_clen   = 16'd0;
			n_ccnt   = 16'd0;
			n_cnt    = 16'd0;
			n_roff   = 32'd0;
			n_type   = FT_TEXT;
			n_lenbad = 1'b0;
		end else if (accept && phase_q != PH_WAIT) begin
			n_bp = bp_inc;
			case (phase_q)
				PH_MAGIC2: begin
					if (low_q == GZIP_ID1 && data_byte == GZIP_ID2) begin
						n_type  = FT_GZIP;
						n_phase = PH_METHOD;
					end else begin
						n_type    = FT_TEXT;
						n_phase   = PH_WAIT;
						has_final = 1'b1;
						fin_ev    = EV_DONE;
					end
				end
				PH_METHOD: n_phase = PH_FLAGS;
				PH_FLAGS: begin
					n_flags = data_byte;
					n_phase = PH_MTIME;
					n_step  = 2'd0;
				end
				PH_MTIME: begin
					n_mtime = mtime_q | ({24'd0, data_byte} << {step_q, 3'b000});
					n_step  = step_q + 2'd1;
					if (step_q == 2'd3) begin
						n_phase = PH_XFL;
					end
				end
				PH_XFL: n_phase = PH_OS;
				PH_OS: begin
					n_os = data_byte;
					if (flags_q[FLG_FEXTRA]) begin
						n_phase = PH_XLEN;
						n_step  = 2'd0;
					end else begin
						tail_req = 1'b1;
					end
				end
				PH_XLEN: begin
					if (step_q == 2'd0) begin
						n_low  = data_byte;
						n_step = 2'd1;
					end else begin
						n_xend = xend_calc;
						if (word >= 16'd2) begin
							n_phase = PH_SI1;
						end else if (bp_inc >= {15'd0, xend_calc}) begin
							tail_req = 1'b1;
						end else begin
							n_phase = PH_SKIP;
						end
					end
				end
				PH_SI1: begin
					n_sub   = data_byte;
					n_phase = PH_SI2;
				end
				PH_SI2: begin
					if (sub_q == SUB_ID1 && data_byte == SUB_ID2) begin
						n_phase = PH_SUBLEN;
						n_step  = 2'd0;
					end else if (bp_inc >= {15'd0, xend_q}) begin
						tail_req = 1'b1;
					end else begin
						n_phase = PH_SKIP;
					end
				end
				PH_SUBLEN: begin
					if (step_q == 2'd0) begin
						n_low  = data_byte;
						n_step = 2'd1;
					end else begin
						n_phase = PH_VERSION;
						n_step  = 2'd0;
					end
				end
				PH_VERSION: begin
					if (step_q == 2'd0) begin
						n_low  = data_byte;
						n_step = 2'd1;
					end else if (word != 16'd1) begin
						n_phase   = PH_WAIT;
						has_final = 1'b1;
						fin_ev    = EV_BAD_VERSION;
					end else begin
						n_phase = PH_CLEN;
						n_step  = 2'd0;
					end
				end
				PH_CLEN: begin
					if (step_q == 2'd0) begin
						n_low  = data_byte;
						n_step = 2'd1;
					end else begin
						n_clen  = word;
						n_phase = PH_CCNT;
						n_step  = 2'd0;
					end
				end
				PH_CCNT: begin
					if (step_q == 2'd0) begin
						n_low  = data_byte;
						n_step = 2'd1;
					end else begin
						n_ccnt = word;
						if (word == 16'd0) begin
							n_phase   = PH_WAIT;
							has_final = 1'b1;
							fin_ev    = EV_ZERO_CHUNKS;
						end else begin
							n_phase = PH_TABLE;
							n_step  = 2'd0;
							n_cnt   = 16'd0;
							n_roff  = 32'd0;
						end
					end
				end
				PH_TABLE: begin
					if (step_q == 2'd0) begin
						n_low  = data_byte;
						n_step = 2'd1;
					end else begin
						n_step    = 2'd0;
						has_chunk = 1'b1;
						n_roff    = roff_q + {16'd0, word};
						n_cnt     = cnt_inc;
						if (cnt_inc == ccnt_q) begin
							n_type   = FT_DICTZIP;
							n_lenbad = (bp_inc != {15'd0, xend_q});
							tail_req = 1'b1;
						end
					end
				end
				PH_SKIP: begin
					if (bp_inc >= {15'd0, xend_q}) begin
						tail_req = 1'b1;
					end
				end
				PH_NAME: begin
					if (data_byte == 8'd0) begin
						tail_req  = 1'b1;
						tail_from = 2'd1;
					end
				end
				PH_COMMENT: begin
					if (data_byte == 8'd0) begin
						tail_req  = 1'b1;
						tail_from = 2'd2;
					end
				end
				PH_HCRC: begin
					if (step_q == 2'd0) begin
						n_step = 2'd1;
					end else begin
						tail_req  = 1'b1;
						tail_from = 2'd3;
					end
				end
				default: n_phase = PH_WAIT;
			endcase
			if (tail_req) begin
				if (tail_from == 2'd0 && flags_q[FLG_FNAME]) begin
					n_phase = PH_NAME;
				end else if (tail_from <= 2'd1 && flags_q[FLG_FCOMMENT]) begin
					n_phase = PH_COMMENT;
				end else if (tail_from <= 2'd2 && flags_q[FLG_FHCRC]) begin
					n_phase = PH_HCRC;
					n_step  = 2'd0;
				end else begin
					n_phase   = PH_WAIT;
					has_final = 1'b1;
					fin_ev    = n_lenbad ? EV_LEN_MISMATCH : EV_DONE;
					fin_start = n_lenbad ? 32'd0 : n_bp;
				end
			end
		end
	end

	assign push = has_chunk || has_final;

	always_comb begin
		push_entry.has_chunk    = has_chunk;
		push_entry.has_final    = has_final;
		push_entry.final_ev     = fin_ev;
		push_entry.chunk_type   = type_q;
		push_entry.file_type    = n_type;
		push_entry.flag_bits    = n_flags;
		push_entry.mod_time     = n_mtime;
		push_entry.os_code      = n_os;
		push_entry.chunk_length = n_clen;
		push_entry.chunk_count  = n_ccnt;
		push_entry.data_start   = fin_start;
		push_entry.chunk_index  = cnt_q;
		push_entry.chunk_size   = word;
		push_entry.chunk_offset = roff_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
		end else begin
			phase_q <= n_phase;
		end
	end

	always_ff @(posedge clk) begin
		bp_q     <= n_bp;
		step_q   <= n_step;
		low_q    <= n_low;
		flags_q  <= n_flags;
		mtime_q  <= n_mtime;
		os_q     <= n_os;
		xend_q   <= n_xend;
		sub_q    <= n_sub;
		clen_q   <= n_clen;
		ccnt_q   <= n_ccnt;
		cnt_q    <= n_cnt;
		roff_q   <= n_roff;
		type_q   <= n_type;
		lenbad_q <= n_lenbad;
	end

endmodule

// ===== rtl/core/dzhp_queue.sv =====
// Short queue of result entries between the parser front and the output back end.
// Depends on dzhp_pkg for the entry and status types.
module dzhp_queue
	import dzhp_pkg::*;
#(
	parameter int DEPTH = 4
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  dzhp_entry_t push_entry,
	input  logic        pop,
	output dzhp_entry_t head,
	output dzhp_qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dzhp_entry_t    mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign qstat.full      = (count_q == CW'(DEPTH));
	assign qstat.not_empty = (count_q != '0);
	assign do_push         = push && !qstat.full;
	assign do_pop          = pop && qstat.not_empty;
	assign head            = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/core/dzhp_back.sv =====
// Back end of the dictzip header parser: turns queue entries into output beats.
// An entry holding a chunk and a final event goes out as two beats. Depends on dzhp_pkg.
module dzhp_back
	import dzhp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  dzhp_qstat_t            qstat,
	input  dzhp_entry_t            head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [2:0]             m_tuser,
	output logic                   m_tlast
);

	logic                   tvalid_q;
	logic                   half_q;
	logic [OUT_TDATA_W-1:0] tdata_q;
	dzhp_event_t            tuser_q;
	logic                   tlast_q;
	logic                   load;
	logic                   send_chunk;
	logic [OUT_TDATA_W-1:0] beat_data;

	assign load       = qstat.not_empty && (!tvalid_q || m_tready);
	assign send_chunk = head.has_chunk && !half_q;
	assign pop        = load && !(send_chunk && head.has_final);

	always_comb begin
		if (send_chunk) begin
			beat_data = {6'd0, head.chunk_offset, head.chunk_size, head.chunk_index,
				32'd0, head.chunk_count, head.chunk_length, head.os_code,
				head.mod_time, head.flag_bits, head.chunk_type};
		end else begin
			beat_data = {6'd0, 32'd0, 16'd0, 16'd0,
				head.data_start, head.chunk_count, head.chunk_length, head.os_code,
				head.mod_time, head.flag_bits, head.file_type};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			half_q   <= 1'b0;
		end else begin
			if (load) begin
				tvalid_q <= 1'b1;
				half_q   <= !pop;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= beat_data;
			tuser_q <= send_chunk ? EV_CHUNK : head.final_ev;
			tlast_q <= send_chunk ? !head.has_final : 1'b1;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

endmodule

// ===== rtl/core/dzhp_checker.sv =====
// Port-level checks of the dictzip header parser, bound to its top level.
// Depends on dzhp_pkg and dictzip_header_parser_top_assert.svh.
`include "dictzip_header_parser_top_assert.svh"

module dzhp_checker
	import dzhp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [2:0]             m_axis_tuser,
	input logic                   m_axis_tlast
);

	`DZHP_ASSERT_NOW(a_event_range, clk, arst_n, m_axis_tvalid, m_axis_tuser <= EV_LEN_MISMATCH)
	`DZHP_ASSERT_NOW(a_mid_is_chunk, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == EV_CHUNK)
	`DZHP_ASSERT_NOW(a_chunk_gzip, clk, arst_n, m_axis_tvalid && m_axis_tuser == EV_CHUNK, m_axis_tdata[1:0] == FT_GZIP)
	`DZHP_ASSERT_NOW(a_final_no_entry, clk, arst_n, m_axis_tvalid && m_axis_tuser != EV_CHUNK, m_axis_tdata[177:114] == 64'd0)
	`DZHP_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind dictzip_header_parser_top dzhp_checker u_dzhp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
